@@ hw/rtl/bctd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package bctd_pkg;

  localparam int unsigned TEXELS     = 16;
  localparam int unsigned CIDX_W     = 2;
  localparam int unsigned AIDX_W     = 3;
  localparam int unsigned TEXEL_W    = 4;
  localparam int unsigned CHAN_W     = 8;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [TEXEL_W-1:0] TEXEL_LAST  = 4'd15;

  // Decoded block as it travels from the front to the back.
  typedef struct packed {
    logic [3:0][CHAN_W-1:0]        pal_r;
    logic [3:0][CHAN_W-1:0]        pal_g;
    logic [3:0][CHAN_W-1:0]        pal_b;
    logic [7:0][CHAN_W-1:0]        pal_a;
    logic [TEXELS*CIDX_W-1:0]      color_idx;
    logic [TEXELS*AIDX_W-1:0]      alpha_idx;
    logic                          dxt5;
  } blk_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/bctd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bctd_front
  import bctd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_color_block,
  input  wire logic [63:0] in_alpha_block,
  input  wire logic        format_mode,
  input  q_stat_t          q_stat,
  output logic             push,
  output blk_t             push_blk
);

  // Reciprocals: exact floor division over the value ranges used here.
  localparam logic [9:0]  RECIP3 = 10'd683;   // x <= 765,  shift 11
  localparam logic [11:0] RECIP7 = 12'd2341;  // x <= 1785, shift 14
  localparam logic [10:0] RECIP5 = 11'd1639;  // x <= 1275, shift 13

  logic        f_valid_r, f_valid_nxt;
  logic [63:0] cb_r, ab_r;
  logic        mode_r;
  logic        accept;

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = x * RECIP3;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = x * RECIP7;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = x * RECIP5;
    return p[20:13];
  endfunction

  assign busy   = f_valid_r && q_stat.full;
  assign accept = start && !busy;
  assign push   = f_valid_r && !q_stat.full;
  assign f_valid_nxt = accept || (f_valid_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    if (accept) begin
      cb_r   <= in_color_block;
      ab_r   <= in_alpha_block;
      mode_r <= format_mode;
    end
  end

  logic [15:0] c0, c1;
  logic [2:0][7:0] e0, e1;
  logic [7:0] a0, a1;

  assign c0 = cb_r[15:0];
  assign c1 = cb_r[31:16];
  assign a0 = ab_r[7:0];
  assign a1 = ab_r[15:8];

  // Replicate high bits into the low bits: channel 0 red, 1 green, 2 blue.
  assign e0[0] = {c0[15:11], c0[15:13]};
  assign e0[1] = {c0[10:5], c0[10:9]};
  assign e0[2] = {c0[4:0], c0[4:2]};
  assign e1[0] = {c1[15:11], c1[15:13]};
  assign e1[1] = {c1[10:5], c1[10:9]};
  assign e1[2] = {c1[4:0], c1[4:2]};

  always_comb begin
    logic [3:0][7:0] pal [3];
    logic [9:0]  s_a, s_b;
    logic [8:0]  s_m;
    logic [10:0] s7;
    logic [10:0] s5;
    for (int ch = 0; ch < 3; ch++) begin
      s_a = {2'b00, e0[ch]} + {2'b00, e0[ch]} + {2'b00, e1[ch]};
      s_b = {2'b00, e0[ch]} + {2'b00, e1[ch]} + {2'b00, e1[ch]};
      s_m = {1'b0, e0[ch]} + {1'b0, e1[ch]};
      pal[ch][0] = e0[ch];
      pal[ch][1] = e1[ch];
      if (c0 > c1) begin
        pal[ch][2] = div3(s_a);
        pal[ch][3] = div3(s_b);
      end else begin
        pal[ch][2] = s_m[8:1];
        pal[ch][3] = 8'h00;
      end
    end
    push_blk.pal_r = pal[0];
    push_blk.pal_g = pal[1];
    push_blk.pal_b = pal[2];

    push_blk.pal_a[0] = a0;
    push_blk.pal_a[1] = a1;
    for (int k = 2; k < 8; k++) begin
      s7 = 11'((8 - k) * int'(a0) + (k - 1) * int'(a1));
      s5 = 11'(((6 - k) > 0 ? (6 - k) : 0) * int'(a0) + (k - 1) * int'(a1));
      if (a0 > a1) begin
        push_blk.pal_a[k] = div7(s7);
      end else if (k == 6) begin
        push_blk.pal_a[k] = ALPHA_CLEAR;
      end else if (k == 7) begin
        push_blk.pal_a[k] = ALPHA_OPAQUE;
      end else begin
        push_blk.pal_a[k] = div5(s5);
      end
    end

    push_blk.color_idx = cb_r[63:32];
    push_blk.alpha_idx = ab_r[63:16];
    push_blk.dxt5      = mode_r;
  end

endmodule
`default_nettype wire

@@ hw/rtl/bctd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bctd_queue
  import bctd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  blk_t      wr_blk,
  input  wire logic rd_en,
  output blk_t      rd_blk,
  output q_stat_t   q_stat
);

  blk_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign rd_blk       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_blk;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bctd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module bctd_back
  import bctd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  q_stat_t                  q_stat,
  input  blk_t                     head_blk,
  output logic                     pop,
  output logic                     out_valid,
  output logic [CHAN_W-1:0]        out_red,
  output logic [CHAN_W-1:0]        out_green,
  output logic [CHAN_W-1:0]        out_blue,
  output logic [CHAN_W-1:0]        out_alpha,
  output logic [TEXEL_W-1:0]       out_texel_index,
  output logic                     out_last
);

  logic [TEXEL_W-1:0] cnt_r;
  logic               emit;
  logic [CIDX_W-1:0]  ci;
  logic [AIDX_W-1:0]  ai;
  logic [5:0]         abase;

  logic                out_valid_r;
  logic [CHAN_W-1:0]   red_r, green_r, blue_r, alpha_r;
  logic [TEXEL_W-1:0]  tidx_r;
  logic                last_r;

  assign emit  = !q_stat.empty;
  assign pop   = emit && (cnt_r == TEXEL_LAST);
  assign abase = 6'(cnt_r) * 6'd3;
  assign ci    = head_blk.color_idx[{cnt_r, 1'b0} +: CIDX_W];
  assign ai    = head_blk.alpha_idx[abase +: AIDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
      if (emit) begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
    // Payload advances with each texel; no reset needed.
    if (emit) begin
      red_r   <= head_blk.pal_r[ci];
      green_r <= head_blk.pal_g[ci];
      blue_r  <= head_blk.pal_b[ci];
      alpha_r <= head_blk.dxt5 ? head_blk.pal_a[ai] : ALPHA_OPAQUE;
      tidx_r  <= cnt_r;
      last_r  <= (cnt_r == TEXEL_LAST);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = red_r;
  assign out_green       = green_r;
  assign out_blue        = blue_r;
  assign out_alpha       = alpha_r;
  assign out_texel_index = tidx_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

@@ hw/rtl/bc_texture_block_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// DXT1/DXT5 4x4 block decoder. A block is taken when start is high and busy
// is low; its sixteen texels come out in row-major order, one per cycle,
// each marked by out_valid for a single cycle, with out_last on texel 15.
// The receiver cannot stall: texels must be taken as they appear. The first
// texel of a block passes the front register, is built into its palette on the
// way into a two-block queue, waits there behind any earlier block, and then
// goes through the output register. The back emits one texel per clock while
// the queue holds a block, so a steady stream of blocks leaves no gaps;
// busy rises only when the front holds a block and the queue is full.
// format_mode (cfg port, always ready) is sampled when a block is taken.
module bc_texture_block_decoder
  import bctd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_format_mode,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_color_block,
  input  wire logic [63:0] in_alpha_block,
  output logic             out_valid,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic [3:0]       out_texel_index,
  output logic             out_last
);

  logic    format_mode_r;
  logic    push, pop;
  blk_t    push_blk, head_blk;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      format_mode_r <= cfg_format_mode;
    end
  end

  bctd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_color_block (in_color_block),
    .in_alpha_block (in_alpha_block),
    .format_mode    (format_mode_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_blk       (push_blk)
  );

  bctd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_blk (push_blk),
    .rd_en  (pop),
    .rd_blk (head_blk),
    .q_stat (q_stat)
  );

  bctd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head_blk        (head_blk),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_texel_index (out_texel_index),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

@@ tb/bc_texture_block_decoder_checker.sv @@
`timescale 1ns / 1ps
module bc_texture_block_decoder_checker
  import bctd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_format_mode,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_color_block,
  input  logic [63:0] in_alpha_block,
  input  logic        out_valid,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic [7:0]  out_alpha,
  input  logic [3:0]  out_texel_index,
  input  logic        out_last,
  output int          mismatches,
  output int          pending_texels
);

  typedef struct packed {
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
    logic [TEXEL_W-1:0] index;
    logic               last;
  } texel_t;

  texel_t texel_q[$];
  logic   dxt5_mode = 1'b0;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Expand one block into its sixteen texels and queue them.
  task automatic decode_block(input logic [63:0] color, input logic [63:0] alph,
                              input logic dxt5);
    int unsigned cpal[4][3];
    int unsigned apal[8];
    int unsigned e0, e1, a0, a1, ci, ai;
    logic [15:0] c0, c1;
    texel_t      t;
    c0 = color[15:0];
    c1 = color[31:16];
    cpal[0][0] = widen5(c0[15:11]);
    cpal[0][1] = widen6(c0[10:5]);
    cpal[0][2] = widen5(c0[4:0]);
    cpal[1][0] = widen5(c1[15:11]);
    cpal[1][1] = widen6(c1[10:5]);
    cpal[1][2] = widen5(c1[4:0]);
    for (int ch = 0; ch < 3; ch++) begin
      e0 = cpal[0][ch];
      e1 = cpal[1][ch];
      if (c0 > c1) begin
        cpal[2][ch] = (2 * e0 + e1) / 3;
        cpal[3][ch] = (e0 + 2 * e1) / 3;
      end else begin
        cpal[2][ch] = (e0 + e1) / 2;
        cpal[3][ch] = 0;
      end
    end
    a0 = alph[7:0];
    a1 = alph[15:8];
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 2; k < 8; k++) apal[k] = ((8 - k) * a0 + (k - 1) * a1) / 7;
    end else begin
      for (int k = 2; k < 6; k++) apal[k] = ((6 - k) * a0 + (k - 1) * a1) / 5;
      apal[6] = ALPHA_CLEAR;
      apal[7] = ALPHA_OPAQUE;
    end
    for (int i = 0; i < TEXELS; i++) begin
      ci = color[32 + 2 * i +: 2];
      ai = alph[16 + 3 * i +: 3];
      t.red   = 8'(cpal[ci][0]);
      t.green = 8'(cpal[ci][1]);
      t.blue  = 8'(cpal[ci][2]);
      t.alpha = dxt5 ? 8'(apal[ai]) : ALPHA_OPAQUE;
      t.index = 4'(i);
      t.last  = (4'(i) == TEXEL_LAST);
      texel_q.push_back(t);
    end
  endtask

  task automatic check_texel();
    texel_t want;
    if (texel_q.size() == 0) begin
      note_mismatch("texel with nothing pending, index", out_texel_index, 'x);
    end else begin
      want = texel_q.pop_front();
      if (out_red !== want.red) note_mismatch("red", out_red, want.red);
      if (out_green !== want.green) note_mismatch("green", out_green, want.green);
      if (out_blue !== want.blue) note_mismatch("blue", out_blue, want.blue);
      if (out_alpha !== want.alpha) note_mismatch("alpha", out_alpha, want.alpha);
      if (out_texel_index !== want.index)
        note_mismatch("texel_index", out_texel_index, want.index);
      if (out_last !== want.last) note_mismatch("last", out_last, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      texel_q.delete();
      dxt5_mode = 1'b0;
      mismatches = 0;
    end else begin
      if (out_valid !== 1'b0) check_texel();
      // format_mode is sampled when the block is taken
      if (start && !busy) decode_block(in_color_block, in_alpha_block, dxt5_mode);
      if (cfg_valid && cfg_ready) dxt5_mode = cfg_format_mode;
    end
    pending_texels = texel_q.size();
  end

endmodule

@@ tb/bc_texture_block_decoder_test.sv @@
`timescale 1ns / 1ps
module bc_texture_block_decoder_test;

  localparam logic [31:0] COLOR_RAMP = 32'hE4E4E4E4;  // indices 0,1,2,3 repeating
  localparam logic [47:0] ALPHA_RAMP = 48'hFAC688FAC688;  // indices 0..7 twice

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_format_mode = 1'b0;
  logic        start = 1'b0;
  logic [63:0] in_color_block = '0;
  logic [63:0] in_alpha_block = '0;
  logic        cfg_ready, busy, out_valid, out_last;
  logic [7:0]  out_red, out_green, out_blue, out_alpha;
  logic [3:0]  out_texel_index;
  int          mismatches, pending_texels;
  logic        idling = 1'b1;

  always #4 clk = ~clk;

  bc_texture_block_decoder u_dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_format_mode, .start, .busy,
    .in_color_block, .in_alpha_block, .out_valid, .out_red, .out_green,
    .out_blue, .out_alpha, .out_texel_index, .out_last
  );

  bc_texture_block_decoder_checker u_checker (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_format_mode, .start, .busy,
    .in_color_block, .in_alpha_block, .out_valid, .out_red, .out_green,
    .out_blue, .out_alpha, .out_texel_index, .out_last, .mismatches,
    .pending_texels
  );

  // Hold start until the block takes the word; leave start high on return.
  task automatic send_block(input logic [63:0] color, input logic [63:0] alph);
    in_color_block <= color;
    in_alpha_block <= alph;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    if (idling && $urandom_range(99) < 12) begin
      start <= 1'b0;
      in_color_block <= {$urandom, $urandom};
      in_alpha_block <= {$urandom, $urandom};
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending_texels != 0);
    @(posedge clk);
  endtask

  task automatic write_mode(input logic dxt5);
    cfg_format_mode <= dxt5;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [63:0] color, alph;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // DXT1: alpha half ignored, every palette branch
    write_mode(1'b0);
    send_block({COLOR_RAMP, 16'h0000, 16'hFFFF}, '1);
    idle_gap();
    send_block({COLOR_RAMP, 16'hFFFF, 16'h0000}, '1);
    idle_gap();
    send_block({COLOR_RAMP, 16'h1234, 16'h1234}, '0);
    idle_gap();
    send_block('0, '0);
    idle_gap();
    send_block('1, '1);
    idle_gap();
    send_block({COLOR_RAMP, 16'h07E0, 16'hF81F}, {ALPHA_RAMP, 16'h00FF});
    drain();

    // DXT5: both alpha palette shapes and their extremes
    write_mode(1'b1);
    send_block({COLOR_RAMP, 16'h0000, 16'hFFFF}, {ALPHA_RAMP, 8'h00, 8'hFF});
    idle_gap();
    send_block({COLOR_RAMP, 16'h0000, 16'hFFFF}, {ALPHA_RAMP, 8'hFF, 8'h00});
    idle_gap();
    send_block({COLOR_RAMP, 16'hFFFF, 16'h0000}, {ALPHA_RAMP, 8'h80, 8'h80});
    idle_gap();
    send_block({COLOR_RAMP, 16'h0000, 16'h0000}, '0);
    idle_gap();
    send_block('1, '1);
    idle_gap();
    send_block({COLOR_RAMP, 16'hF81F, 16'h07E0}, {ALPHA_RAMP, 8'd3, 8'd250});
    idle_gap();
    send_block({32'h1B1B1B1B, 16'h8410, 16'h7BEF}, {ALPHA_RAMP, 8'd200, 8'd7});
    idle_gap();
    send_block({32'h4E4E4E4E, 16'h001F, 16'hF800}, {~ALPHA_RAMP, 8'd1, 8'd0});
    idle_gap();
    send_block({32'hB1B1B1B1, 16'hFFFE, 16'hFFFF}, {~ALPHA_RAMP, 8'd255, 8'd254});
    drain();

    for (int n = 0; n < 250; n++) begin
      if (n % 50 == 0) begin
        drain();
        write_mode(1'($urandom_range(1)));
      end
      idling = !(n >= 100 && n < 160);
      color = {$urandom, $urandom};
      alph = {$urandom, $urandom};
      case ($urandom_range(7))
        0: color[31:16] = color[15:0];
        1: alph[15:8] = alph[7:0];
        2: color[31:0] = {$urandom_range(1) ? 16'hFFFF : 16'h0000,
                          $urandom_range(1) ? 16'hFFFF : 16'h0000};
        3: alph[15:0] = {$urandom_range(1) ? 8'hFF : 8'h00,
                         $urandom_range(1) ? 8'hFF : 8'h00};
        default: ;
      endcase
      send_block(color, alph);
      idle_gap();
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("bc_texture_block_decoder_test: PASS");
    end else begin
      $display("bc_texture_block_decoder_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("bc_texture_block_decoder_test: FAIL");
    $finish;
  end

endmodule
